>>> rtl/gcnl_pkg.sv
// shared widths, register indexes, types and helpers of the grid cell neighbor lister
package gcnl_pkg;

    // table and field sizes
    localparam int SLOTS      = 256;
    localparam int SLOT_W     = 8;
    localparam int POS_W      = 24;
    localparam int DIFF_W     = POS_W + 1;
    localparam int SIZE_W     = 23;
    localparam int CNT_W      = 11;
    localparam int AXIS_W     = 10;
    localparam int ID_W       = 20;
    localparam int RAD_W      = 2;
    localparam int SPAN_W     = 3;
    localparam int MAX_CELLS  = 1024;

    // serial step counts
    localparam int DIV_STEPS  = POS_W;
    localparam int MUL_STEPS  = CNT_W;
    localparam int STEP_W     = 5;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_W      = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_WIDTH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_HEIGHT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_ACROSS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_DOWN   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_RADIUS  = 3'd6;

    // control of one serial divider lane
    typedef struct packed {
        logic load;
        logic step;
    } t_div_ctl;

    // grid size per axis: zero acts as one, large values saturate
    function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] n);
        logic [CNT_W-1:0] res;
        if (n == '0) begin
            res = CNT_W'(1);
        end else if (n > CNT_W'(MAX_CELLS)) begin
            res = CNT_W'(MAX_CELLS);
        end else begin
            res = n;
        end
        return res;
    endfunction

    // cell size: zero acts as one
    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
        return (s == '0) ? SIZE_W'(1) : s;
    endfunction

    // smaller of the radius and a cell distance
    function automatic logic [RAD_W-1:0] min_rad(input logic [RAD_W-1:0] r,
                                                 input logic [AXIS_W-1:0] v);
        return (v < AXIS_W'(r)) ? v[RAD_W-1:0] : r;
    endfunction

endpackage

>>> rtl/gcnl_ram.sv
// generic single write port ram with registered read
module gcnl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/gcnl_div_lane.sv
// bit-serial restoring divider for one axis, one quotient bit per cycle while step is high
module gcnl_div_lane (
    input  logic                          i_clk,
    input  gcnl_pkg::t_div_ctl            i_ctl,
    input  logic [gcnl_pkg::POS_W-1:0]    i_dividend,
    input  logic [gcnl_pkg::SIZE_W-1:0]   i_divisor,
    output logic [gcnl_pkg::POS_W-1:0]    o_quotient
);

    logic [gcnl_pkg::POS_W-1:0]  r_dvd;
    logic [gcnl_pkg::SIZE_W-1:0] r_rem;
    logic [gcnl_pkg::SIZE_W-1:0] r_dsr;
    logic [gcnl_pkg::SIZE_W:0]   trial;
    logic [gcnl_pkg::SIZE_W:0]   trial_sub;
    logic                        q_bit;

    // shift the next dividend bit into the partial remainder and try the subtract
    always_comb begin
        trial     = {r_rem, r_dvd[gcnl_pkg::POS_W-1]};
        trial_sub = trial - {1'b0, r_dsr};
        q_bit     = (trial >= {1'b0, r_dsr});
    end

    // quotient bits replace dividend bits from the bottom
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
            r_dsr <= gcnl_pkg::eff_size(i_divisor);
        end else if (i_ctl.step) begin
            r_dvd <= {r_dvd[gcnl_pkg::POS_W-2:0], q_bit};
            r_rem <= q_bit ? trial_sub[gcnl_pkg::SIZE_W-1:0]
                           : trial[gcnl_pkg::SIZE_W-1:0];
        end
    end

    assign o_quotient = r_dvd;

endmodule

>>> rtl/grid_cell_neighbor_lister.sv
// top level of the grid cell neighbor lister
//
// Each input beat carries an entity slot and a Q15.8 position. The block turns the position
// into a clamped row-major cell id, compares it with the cell last stored for that slot,
// and then sends either one beat with no neighbor (cell unchanged) or one beat for every
// in-bounds cell within view_radius of the new cell, rows top to bottom, columns left to
// right, with tlast on the final beat. One item is taken at a time, and an item yields 1 to 49
// result beats. The bit-serial divider (both axes in parallel), the clamp, the bit-serial
// multiplier for the row-major id and the setup step come first; the listing then sends one
// beat per cycle while the output is not stalled. The slot table comes out of reset empty at
// once (a valid flag per slot), so no clearing pass follows reset. Configuration must be
// written only while idle; the block itself does not enforce this.
module grid_cell_neighbor_lister (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write port
    input  logic                              i_cfg_we,
    input  logic [gcnl_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [gcnl_pkg::CFG_W-1:0]        i_cfg_data,
    // input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [55:0]                       s_axis_tdata,  // slot[7:0], pos_x[31:8], pos_y[55:32]
    // result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [39:0]                       m_axis_tdata,  // cell_id[19:0], neighbor_id[39:20]
    output logic [1:0]                        m_axis_tuser,  // cell_changed[0], neighbor_valid[1]
    output logic                              m_axis_tlast
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIV   = 3'd1;
    localparam logic [2:0] ST_CLAMP = 3'd2;
    localparam logic [2:0] ST_MUL   = 3'd3;
    localparam logic [2:0] ST_SETUP = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;

    // configuration registers
    logic [gcnl_pkg::POS_W-1:0]  r_org_x;
    logic [gcnl_pkg::POS_W-1:0]  r_org_y;
    logic [gcnl_pkg::SIZE_W-1:0] r_cell_w;
    logic [gcnl_pkg::SIZE_W-1:0] r_cell_h;
    logic [gcnl_pkg::CNT_W-1:0]  r_across;
    logic [gcnl_pkg::CNT_W-1:0]  r_down;
    logic [gcnl_pkg::RAD_W-1:0]  r_radius;

    // control and working registers
    logic [2:0]                    r_state;
    logic [2:0]                    n_state;
    logic [gcnl_pkg::STEP_W-1:0]   r_cnt;
    logic [gcnl_pkg::SLOT_W-1:0]   r_slot;
    logic [gcnl_pkg::SLOTS-1:0]    r_slot_valid;
    logic [gcnl_pkg::AXIS_W-1:0]   r_gx;
    logic [gcnl_pkg::AXIS_W-1:0]   r_gy;
    logic [gcnl_pkg::ID_W-1:0]     r_acc;
    logic [gcnl_pkg::ID_W-1:0]     r_mcand;
    logic [gcnl_pkg::CNT_W-1:0]    r_mplier;
    logic                          r_changed;
    logic [gcnl_pkg::SPAN_W-1:0]   r_span_x;
    logic [gcnl_pkg::SPAN_W-1:0]   r_span_y;
    logic [gcnl_pkg::SPAN_W-1:0]   r_col;
    logic [gcnl_pkg::SPAN_W-1:0]   r_row;
    logic [gcnl_pkg::ID_W-1:0]     r_row_start;
    logic [gcnl_pkg::ID_W-1:0]     r_nbr;

    // output register
    logic                          r_ovalid;
    logic [gcnl_pkg::ID_W-1:0]     r_o_cell;
    logic [gcnl_pkg::ID_W-1:0]     r_o_nbr;
    logic                          r_o_chg;
    logic                          r_o_nvld;
    logic                          r_o_last;

    // combinational helpers
    logic                          in_acc;
    logic [gcnl_pkg::SLOT_W-1:0]   in_slot;
    logic [gcnl_pkg::POS_W-1:0]    in_px;
    logic [gcnl_pkg::POS_W-1:0]    in_py;
    logic [gcnl_pkg::DIFF_W-1:0]   diff_x;
    logic [gcnl_pkg::DIFF_W-1:0]   diff_y;
    logic [gcnl_pkg::POS_W-1:0]    dvd_x;
    logic [gcnl_pkg::POS_W-1:0]    dvd_y;
    gcnl_pkg::t_div_ctl            div_ctl;
    logic [gcnl_pkg::POS_W-1:0]    quo_x;
    logic [gcnl_pkg::POS_W-1:0]    quo_y;
    logic [gcnl_pkg::CNT_W-1:0]    nx;
    logic [gcnl_pkg::CNT_W-1:0]    ny;
    logic [gcnl_pkg::CNT_W-1:0]    nx_m1_full;
    logic [gcnl_pkg::CNT_W-1:0]    ny_m1_full;
    logic [gcnl_pkg::AXIS_W-1:0]   nx_m1;
    logic [gcnl_pkg::AXIS_W-1:0]   ny_m1;
    logic [gcnl_pkg::AXIS_W-1:0]   gx_c;
    logic [gcnl_pkg::AXIS_W-1:0]   gy_c;
    logic [gcnl_pkg::RAD_W-1:0]    lo_x;
    logic [gcnl_pkg::RAD_W-1:0]    lo_y;
    logic [gcnl_pkg::RAD_W-1:0]    hi_x;
    logic [gcnl_pkg::RAD_W-1:0]    hi_y;
    logic [gcnl_pkg::ID_W-1:0]     nx_ext;
    logic [gcnl_pkg::ID_W-1:0]     lo_y_nx;
    logic [gcnl_pkg::ID_W-1:0]     row0;
    logic [gcnl_pkg::ID_W-1:0]     ram_rdata;
    logic                          cell_chg;
    logic                          ram_we;
    logic                          out_free;
    logic                          end_pt;
    logic                          emit_last;
    logic                          div_done;
    logic                          mul_done;

    // unpack the input beat and form the origin-relative dividends
    always_comb begin
        in_acc  = s_axis_tvalid && s_axis_tready;
        in_slot = s_axis_tdata[7:0];
        in_px   = s_axis_tdata[31:8];
        in_py   = s_axis_tdata[55:32];
        diff_x  = {in_px[gcnl_pkg::POS_W-1], in_px} - {r_org_x[gcnl_pkg::POS_W-1], r_org_x};
        diff_y  = {in_py[gcnl_pkg::POS_W-1], in_py} - {r_org_y[gcnl_pkg::POS_W-1], r_org_y};
        dvd_x   = diff_x[gcnl_pkg::DIFF_W-1] ? '0 : diff_x[gcnl_pkg::POS_W-1:0];
        dvd_y   = diff_y[gcnl_pkg::DIFF_W-1] ? '0 : diff_y[gcnl_pkg::POS_W-1:0];
        div_ctl.load = in_acc;
        div_ctl.step = (r_state == ST_DIV);
    end

    // serial dividers, one per axis
    gcnl_div_lane u_div_x (
        .i_clk      (i_clk),
        .i_ctl      (div_ctl),
        .i_dividend (dvd_x),
        .i_divisor  (r_cell_w),
        .o_quotient (quo_x)
    );

    gcnl_div_lane u_div_y (
        .i_clk      (i_clk),
        .i_ctl      (div_ctl),
        .i_dividend (dvd_y),
        .i_divisor  (r_cell_h),
        .o_quotient (quo_y)
    );

    // grid bounds and clamping of the quotients
    always_comb begin
        nx         = gcnl_pkg::eff_count(r_across);
        ny         = gcnl_pkg::eff_count(r_down);
        nx_m1_full = nx - gcnl_pkg::CNT_W'(1);
        ny_m1_full = ny - gcnl_pkg::CNT_W'(1);
        nx_m1      = nx_m1_full[gcnl_pkg::AXIS_W-1:0];
        ny_m1      = ny_m1_full[gcnl_pkg::AXIS_W-1:0];
        gx_c       = (quo_x > gcnl_pkg::POS_W'(nx_m1)) ? nx_m1 : quo_x[gcnl_pkg::AXIS_W-1:0];
        gy_c       = (quo_y > gcnl_pkg::POS_W'(ny_m1)) ? ny_m1 : quo_y[gcnl_pkg::AXIS_W-1:0];
        nx_ext     = gcnl_pkg::ID_W'(nx);
    end

    // neighborhood window and first neighbor id
    always_comb begin
        lo_x     = gcnl_pkg::min_rad(r_radius, r_gx);
        lo_y     = gcnl_pkg::min_rad(r_radius, r_gy);
        hi_x     = gcnl_pkg::min_rad(r_radius, nx_m1 - r_gx);
        hi_y     = gcnl_pkg::min_rad(r_radius, ny_m1 - r_gy);
        lo_y_nx  = ({gcnl_pkg::ID_W{lo_y[1]}} & {nx_ext[gcnl_pkg::ID_W-2:0], 1'b0})
                 + ({gcnl_pkg::ID_W{lo_y[0]}} & nx_ext);
        row0     = r_acc - lo_y_nx - gcnl_pkg::ID_W'(lo_x);
        cell_chg = !r_slot_valid[r_slot] || (ram_rdata != r_acc);
        ram_we   = (r_state == ST_SETUP) && cell_chg;
    end

    // per-slot last cell store
    gcnl_ram #(
        .WIDTH (gcnl_pkg::ID_W),
        .DEPTH (gcnl_pkg::SLOTS)
    ) u_last_cell (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_slot),
        .i_wdata (r_acc),
        .i_re    (in_acc),
        .i_raddr (in_slot),
        .o_rdata (ram_rdata)
    );

    // emission status
    always_comb begin
        out_free  = !r_ovalid || m_axis_tready;
        end_pt    = (r_col == r_span_x) && (r_row == r_span_y);
        emit_last = !r_changed || end_pt;
        div_done  = (r_cnt == gcnl_pkg::STEP_W'(gcnl_pkg::DIV_STEPS - 1));
        mul_done  = (r_cnt == gcnl_pkg::STEP_W'(gcnl_pkg::MUL_STEPS - 1));
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_CLAMP;
                end
            end
            ST_CLAMP: begin
                n_state = ST_MUL;
            end
            ST_MUL: begin
                if (mul_done) begin
                    n_state = ST_SETUP;
                end
            end
            ST_SETUP: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free && emit_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org_x  <= '0;
            r_org_y  <= '0;
            r_cell_w <= gcnl_pkg::SIZE_W'(256);
            r_cell_h <= gcnl_pkg::SIZE_W'(256);
            r_across <= gcnl_pkg::CNT_W'(1);
            r_down   <= gcnl_pkg::CNT_W'(1);
            r_radius <= gcnl_pkg::RAD_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                gcnl_pkg::CFG_ORIGIN_X:     r_org_x  <= i_cfg_data[gcnl_pkg::POS_W-1:0];
                gcnl_pkg::CFG_ORIGIN_Y:     r_org_y  <= i_cfg_data[gcnl_pkg::POS_W-1:0];
                gcnl_pkg::CFG_CELL_WIDTH:   r_cell_w <= i_cfg_data[gcnl_pkg::SIZE_W-1:0];
                gcnl_pkg::CFG_CELL_HEIGHT:  r_cell_h <= i_cfg_data[gcnl_pkg::SIZE_W-1:0];
                gcnl_pkg::CFG_CELLS_ACROSS: r_across <= i_cfg_data[gcnl_pkg::CNT_W-1:0];
                gcnl_pkg::CFG_CELLS_DOWN:   r_down   <= i_cfg_data[gcnl_pkg::CNT_W-1:0];
                gcnl_pkg::CFG_VIEW_RADIUS:  r_radius <= i_cfg_data[gcnl_pkg::RAD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_slot_valid <= '0;
            r_ovalid     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (ram_we) begin
                r_slot_valid[r_slot] <= 1'b1;
            end
            if ((r_state == ST_EMIT) && out_free) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // step counter, shift-add multiplier and neighbor walk
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_cnt <= '0;
                if (in_acc) begin
                    r_slot <= in_slot;
                end
            end
            ST_DIV: begin
                r_cnt <= div_done ? '0 : r_cnt + gcnl_pkg::STEP_W'(1);
            end
            ST_CLAMP: begin
                r_gx     <= gx_c;
                r_gy     <= gy_c;
                r_acc    <= gcnl_pkg::ID_W'(gx_c);
                r_mcand  <= gcnl_pkg::ID_W'(gy_c);
                r_mplier <= nx;
            end
            ST_MUL: begin
                r_cnt    <= r_cnt + gcnl_pkg::STEP_W'(1);
                if (r_mplier[0]) begin
                    r_acc <= r_acc + r_mcand;
                end
                r_mcand  <= {r_mcand[gcnl_pkg::ID_W-2:0], 1'b0};
                r_mplier <= {1'b0, r_mplier[gcnl_pkg::CNT_W-1:1]};
            end
            ST_SETUP: begin
                r_changed   <= cell_chg;
                r_span_x    <= gcnl_pkg::SPAN_W'(lo_x) + gcnl_pkg::SPAN_W'(hi_x);
                r_span_y    <= gcnl_pkg::SPAN_W'(lo_y) + gcnl_pkg::SPAN_W'(hi_y);
                r_col       <= '0;
                r_row       <= '0;
                r_row_start <= row0;
                r_nbr       <= row0;
            end
            ST_EMIT: begin
                if (out_free) begin
                    if (r_col == r_span_x) begin
                        r_col       <= '0;
                        r_row       <= r_row + gcnl_pkg::SPAN_W'(1);
                        r_row_start <= r_row_start + nx_ext;
                        r_nbr       <= r_row_start + nx_ext;
                    end else begin
                        r_col <= r_col + gcnl_pkg::SPAN_W'(1);
                        r_nbr <= r_nbr + gcnl_pkg::ID_W'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // output beat payload
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_EMIT) && out_free) begin
            r_o_cell <= r_acc;
            r_o_chg  <= r_changed;
            r_o_nvld <= r_changed;
            r_o_nbr  <= r_changed ? r_nbr : '0;
            r_o_last <= emit_last;
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {r_o_nbr, r_o_cell};
    assign m_axis_tuser  = {r_o_nvld, r_o_chg};
    assign m_axis_tlast  = r_o_last;

    // a beat without a neighbor always closes its item
    a_plain_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[1] |-> m_axis_tlast)
        else $error("beat without neighbor not marked last");

    // neighbors are only listed for a changed cell
    a_nvld_matches_chg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser[1] == m_axis_tuser[0]))
        else $error("neighbor flag disagrees with cell change flag");

    // the walk stays inside the window
    a_walk_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_col <= r_span_x) && (r_row <= r_span_y))
        else $error("neighbor walk left its window");

    // after the table update the slot is known
    a_slot_marked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SETUP) |=> r_slot_valid[r_slot])
        else $error("slot not marked valid after update");

endmodule

>>> bench/gcnl_checker.sv
// beat checker for the grid cell neighbor lister: tracks config, predicts neighbor lists
`timescale 1ns / 100ps

module gcnl_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [gcnl_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [gcnl_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    input  logic [55:0]                    s_axis_tdata,  // slot[7:0], pos_x[31:8], pos_y[55:32]
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic [39:0]                    m_axis_tdata,  // cell_id[19:0], neighbor_id[39:20]
    input  logic [1:0]                     m_axis_tuser,  // cell_changed[0], neighbor_valid[1]
    input  logic                           m_axis_tlast,
    output int                             o_errors,
    output int                             o_pending,
    output int                             o_beats,
    output int                             o_moves,
    output int                             o_stays
);

    // one expected result beat
    typedef struct packed {
        logic [gcnl_pkg::ID_W-1:0] cid;
        logic                      moved;
        logic [gcnl_pkg::ID_W-1:0] nbr;
        logic                      nbr_ok;
        logic                      fin;
    } t_cell_beat;

    // shadow copy of the grid settings
    logic signed [gcnl_pkg::POS_W-1:0]  org_x, org_y;
    logic [gcnl_pkg::SIZE_W-1:0]        size_x, size_y;
    logic [gcnl_pkg::CNT_W-1:0]         cols_n, rows_n;
    logic [gcnl_pkg::RAD_W-1:0]         radius;

    // last cell per slot, bit 20 marks an empty entry
    logic [gcnl_pkg::ID_W:0]            slot_cell [gcnl_pkg::SLOTS];
    t_cell_beat                         cell_beats_due [$];

    int mismatches = 0;
    int beats_seen = 0;
    int moves_seen = 0;
    int stays_seen = 0;

    assign o_errors = mismatches;
    assign o_beats  = beats_seen;
    assign o_moves  = moves_seen;
    assign o_stays  = stays_seen;

    // append one beat to the expected list
    function automatic void queue_beat(input t_cell_beat b);
        cell_beats_due.insert(cell_beats_due.size(), b);
    endfunction

    // usable cells along one axis
    function automatic int grid_count(input logic [gcnl_pkg::CNT_W-1:0] n);
        if (n == 0) begin
            return 1;
        end
        return (n > gcnl_pkg::MAX_CELLS) ? gcnl_pkg::MAX_CELLS : int'(n);
    endfunction

    // truncating divide of the offset from the origin, clamped into the grid
    function automatic int axis_cell_of(input logic signed [gcnl_pkg::POS_W-1:0] pos,
                                        input logic signed [gcnl_pkg::POS_W-1:0] org,
                                        input logic [gcnl_pkg::SIZE_W-1:0] size,
                                        input int count);
        logic signed [gcnl_pkg::DIFF_W-1:0] d;
        longint                             divisor;
        longint                             q;
        d = $signed({pos[gcnl_pkg::POS_W-1], pos}) - $signed({org[gcnl_pkg::POS_W-1], org});
        if (d <= 0) begin
            return 0;
        end
        divisor = (size == 0) ? 64'sd1 : longint'(size);
        q = longint'(d) / divisor;
        if (q > count - 1) begin
            q = count - 1;
        end
        return int'(q);
    endfunction

    // work out the beats that one position update causes
    task automatic list_neighborhood(input logic [gcnl_pkg::SLOT_W-1:0] slot,
                                     input logic [gcnl_pkg::POS_W-1:0] px,
                                     input logic [gcnl_pkg::POS_W-1:0] py);
        int                        nx, ny, r, gx, gy, x0, x1, y0, y1;
        logic [gcnl_pkg::ID_W-1:0] id;
        t_cell_beat                b;
        nx = grid_count(cols_n);
        ny = grid_count(rows_n);
        r  = int'(radius);
        gx = axis_cell_of(px, org_x, size_x, nx);
        gy = axis_cell_of(py, org_y, size_y, ny);
        id = gcnl_pkg::ID_W'(gy * nx + gx);
        b.cid = id;
        if (slot_cell[slot] == {1'b0, id}) begin
            // same cell as before: a single empty beat
            b.moved  = 1'b0;
            b.nbr    = '0;
            b.nbr_ok = 1'b0;
            b.fin    = 1'b1;
            queue_beat(b);
            stays_seen++;
        end else begin
            slot_cell[slot] = {1'b0, id};
            moves_seen++;
            x0 = (gx - r < 0) ? 0 : gx - r;
            x1 = (gx + r > nx - 1) ? nx - 1 : gx + r;
            y0 = (gy - r < 0) ? 0 : gy - r;
            y1 = (gy + r > ny - 1) ? ny - 1 : gy + r;
            // rows top to bottom, columns left to right
            for (int cy = y0; cy <= y1; cy++) begin
                for (int cx = x0; cx <= x1; cx++) begin
                    b.moved  = 1'b1;
                    b.nbr    = gcnl_pkg::ID_W'(cy * nx + cx);
                    b.nbr_ok = 1'b1;
                    b.fin    = (cy == y1) && (cx == x1);
                    queue_beat(b);
                end
            end
        end
    endtask

    // watch config writes, input beats and result beats
    always @(posedge i_clk) begin
        t_cell_beat got;
        t_cell_beat want;
        if (!i_rst_n) begin
            org_x  = '0;
            org_y  = '0;
            size_x = gcnl_pkg::SIZE_W'(256);
            size_y = gcnl_pkg::SIZE_W'(256);
            cols_n = gcnl_pkg::CNT_W'(1);
            rows_n = gcnl_pkg::CNT_W'(1);
            radius = gcnl_pkg::RAD_W'(1);
            for (int i = 0; i < gcnl_pkg::SLOTS; i++) begin
                slot_cell[i] = {1'b1, {gcnl_pkg::ID_W{1'b0}}};
            end
            cell_beats_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    gcnl_pkg::CFG_ORIGIN_X:     org_x  = i_cfg_data;
                    gcnl_pkg::CFG_ORIGIN_Y:     org_y  = i_cfg_data;
                    gcnl_pkg::CFG_CELL_WIDTH:   size_x = i_cfg_data[gcnl_pkg::SIZE_W-1:0];
                    gcnl_pkg::CFG_CELL_HEIGHT:  size_y = i_cfg_data[gcnl_pkg::SIZE_W-1:0];
                    gcnl_pkg::CFG_CELLS_ACROSS: cols_n = i_cfg_data[gcnl_pkg::CNT_W-1:0];
                    gcnl_pkg::CFG_CELLS_DOWN:   rows_n = i_cfg_data[gcnl_pkg::CNT_W-1:0];
                    gcnl_pkg::CFG_VIEW_RADIUS:  radius = i_cfg_data[gcnl_pkg::RAD_W-1:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                list_neighborhood(s_axis_tdata[7:0], s_axis_tdata[31:8], s_axis_tdata[55:32]);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.cid    = m_axis_tdata[19:0];
                got.moved  = m_axis_tuser[0];
                got.nbr    = m_axis_tdata[39:20];
                got.nbr_ok = m_axis_tuser[1];
                got.fin    = m_axis_tlast;
                beats_seen++;
                if (cell_beats_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: expected no beat", $time);
                    $display("%0t:   actual cell %0d changed %0b nbr %0d nbr_ok %0b last %0b",
                             $time, got.cid, got.moved, got.nbr, got.nbr_ok, got.fin);
                end else begin
                    want = cell_beats_due.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        $display("%0t: expected cell %0d changed %0b nbr %0d nbr_ok %0b last %0b",
                                 $time, want.cid, want.moved, want.nbr, want.nbr_ok, want.fin);
                        $display("%0t:   actual cell %0d changed %0b nbr %0d nbr_ok %0b last %0b",
                                 $time, got.cid, got.moved, got.nbr, got.nbr_ok, got.fin);
                    end
                end
            end
        end
        o_pending <= cell_beats_due.size();
    end

endmodule

>>> bench/tb_top.sv
// top of the grid cell neighbor lister bench: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module tb_top;

    localparam int STALL_LIMIT = 4000;

    logic                           i_clk         = 1'b0;
    logic                           i_rst_n       = 1'b0;
    logic                           cfg_we        = 1'b0;
    logic [gcnl_pkg::CFG_IDX_W-1:0] cfg_idx       = '0;
    logic [gcnl_pkg::CFG_W-1:0]     cfg_data      = '0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [55:0]                    s_axis_tdata  = '0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [39:0]                    m_axis_tdata;
    logic [1:0]                     m_axis_tuser;
    logic                           m_axis_tlast;

    int errors, pending, beats, moves, stays;

    int src_idle_pct  = 0;
    int sink_stall_pct = 0;
    int settings_used = 0;
    int quiet_cycles  = 0;

    // grid settings currently loaded, used to aim positions at cells
    int cur_ox = 0, cur_oy = 0, cur_cw = 256, cur_ch = 256, cur_na = 1, cur_nd = 1;

    // last position sent per slot, for repeats that keep the cell
    bit [gcnl_pkg::POS_W-1:0] last_px [gcnl_pkg::SLOTS];
    bit [gcnl_pkg::POS_W-1:0] last_py [gcnl_pkg::SLOTS];
    bit                       slot_used [gcnl_pkg::SLOTS];

    grid_cell_neighbor_lister u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    gcnl_checker u_chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .o_errors      (errors),
        .o_pending     (pending),
        .o_beats       (beats),
        .o_moves       (moves),
        .o_stays       (stays)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // watchdog on cycles with no beat and no config write
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat for %0d cycles, %0d beats still due", $time, quiet_cycles,
                     pending);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // send one position beat, with random idle cycles ahead of it
    task automatic push_pos(input logic [gcnl_pkg::SLOT_W-1:0] slot,
                            input logic [gcnl_pkg::POS_W-1:0] px,
                            input logic [gcnl_pkg::POS_W-1:0] py);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {py, px, slot};
        last_px[slot]   = px;
        last_py[slot]   = py;
        slot_used[slot] = 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
    endtask

    // hold off the sender until every due beat has come back
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic cfg_put(input logic [gcnl_pkg::CFG_IDX_W-1:0] idx, input int val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= gcnl_pkg::CFG_W'(val);
        @(posedge i_clk);
    endtask

    // load a full grid setting, block idle
    task automatic apply_setting(input int ox, input int oy, input int cw, input int ch,
                                 input int na, input int nd, input int rad);
        cfg_put(gcnl_pkg::CFG_ORIGIN_X, ox);
        cfg_put(gcnl_pkg::CFG_ORIGIN_Y, oy);
        cfg_put(gcnl_pkg::CFG_CELL_WIDTH, cw);
        cfg_put(gcnl_pkg::CFG_CELL_HEIGHT, ch);
        cfg_put(gcnl_pkg::CFG_CELLS_ACROSS, na);
        cfg_put(gcnl_pkg::CFG_CELLS_DOWN, nd);
        cfg_put(gcnl_pkg::CFG_VIEW_RADIUS, rad);
        cfg_we <= 1'b0;
        cur_ox = ox;
        cur_oy = oy;
        cur_cw = cw;
        cur_ch = ch;
        cur_na = na;
        cur_nd = nd;
        settings_used++;
    endtask

    function automatic int pick_size();
        case ($urandom_range(15))
            0:       return 0;
            1:       return 8388607;
            default: return int'($urandom_range(1, 1200));
        endcase
    endfunction

    function automatic int pick_count();
        case ($urandom_range(9))
            0:       return 0;
            1:       return 1024;
            2:       return 2047;
            default: return int'($urandom_range(1, 24));
        endcase
    endfunction

    task automatic random_setting();
        apply_setting(int'($urandom_range(65535)) - 32768, int'($urandom_range(65535)) - 32768,
                      pick_size(), pick_size(), pick_count(), pick_count(),
                      int'($urandom_range(3)));
    endtask

    // mostly positions aimed at cells near the grid, some repeats and some noise
    task automatic random_item();
        logic [gcnl_pkg::SLOT_W-1:0] slot;
        logic [gcnl_pkg::POS_W-1:0]  px, py;
        int                          pick, cx, cy, wx, wy, spx, spy;
        slot = ($urandom_range(9) < 7) ? gcnl_pkg::SLOT_W'($urandom_range(15))
                                       : gcnl_pkg::SLOT_W'($urandom);
        pick = int'($urandom_range(99));
        wx   = (cur_cw == 0) ? 1 : cur_cw;
        wy   = (cur_ch == 0) ? 1 : cur_ch;
        spx  = (cur_na == 0) ? 1 : ((cur_na > 40) ? 40 : cur_na);
        spy  = (cur_nd == 0) ? 1 : ((cur_nd > 40) ? 40 : cur_nd);
        if (pick < 25 && slot_used[slot]) begin
            px = last_px[slot];
            py = last_py[slot];
        end else if (pick < 88) begin
            // one cell outside on either side now and then, to hit the clamp
            cx = int'($urandom_range(spx + 1)) - 1;
            cy = int'($urandom_range(spy + 1)) - 1;
            px = gcnl_pkg::POS_W'(cur_ox + cx * wx + int'($urandom_range(wx - 1)));
            py = gcnl_pkg::POS_W'(cur_oy + cy * wy + int'($urandom_range(wy - 1)));
        end else begin
            px = gcnl_pkg::POS_W'($urandom);
            py = gcnl_pkg::POS_W'($urandom);
        end
        push_pos(slot, px, py);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: one cell, radius one; first visit, repeat, far corners
        push_pos(8'd0, 24'h000000, 24'h000000);
        push_pos(8'd0, 24'h000000, 24'h000000);
        push_pos(8'd255, 24'h7FFFFF, 24'h800000);

        // 16 by 16 grid, widest radius
        settle();
        apply_setting(0, 0, 256, 256, 16, 16, 3);
        push_pos(8'd0, 24'h000000, 24'h000000);
        push_pos(8'd1, 24'h000000, 24'h000000);
        push_pos(8'd1, 24'h7FFFFF, 24'h7FFFFF);
        push_pos(8'd2, 24'(8 * 256 + 5), 24'(8 * 256 + 255));
        push_pos(8'd2, 24'(8 * 256 + 100), 24'(8 * 256));
        push_pos(8'd3, 24'h800000, 24'h800000);
        push_pos(8'd3, 24'hFFFFFF, 24'hFFFFFF);
        push_pos(8'd4, 24'd256, 24'd255);
        push_pos(8'd4, 24'd255, 24'd256);
        push_pos(8'd128, 24'(15 * 256), 24'(2 * 256));

        // extreme origins, zero width, oversized column count, radius zero
        settle();
        apply_setting(-8388608, 8388607, 0, 8388607, 2047, 1024, 0);
        push_pos(8'd5, 24'h7FFFFF, 24'h7FFFFF);
        push_pos(8'd5, 24'h800000, 24'h000000);
        push_pos(8'd6, 24'h000001, 24'h800000);
        push_pos(8'd170, 24'h555555, 24'hAAAAAA);

        // zero grid counts and zero height act as one
        settle();
        apply_setting(8388607, -8388608, 8388607, 0, 0, 0, 2);
        push_pos(8'd7, 24'h7FFFFF, 24'h7FFFFF);
        push_pos(8'd85, 24'h2AAAAA, 24'h555555);

        // largest grid, top corner cell id
        settle();
        apply_setting(0, 0, 1, 1, 1024, 1024, 3);
        push_pos(8'd8, 24'h7FFFFF, 24'h7FFFFF);
        push_pos(8'd9, 24'd1023, 24'd0);

        // random part: no idling, sender idle, receiver stall, both
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 46; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 46; end
                default: begin src_idle_pct = 23; sink_stall_pct = 23; end
            endcase
            for (int s = 0; s < 2; s++) begin
                settle();
                random_setting();
                repeat (32) random_item();
            end
        end

        settle();
        repeat (100) @(posedge i_clk);

        $display("covered %0d position updates under %0d grid settings and four idle mixes",
                 moves + stays, settings_used);
        $display("%0d result beats checked: %0d cell changes, %0d unchanged cells",
                 beats, moves, stays);
        if (errors == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
